// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the capture merge core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CSDM_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// condition in this cycle implies consequence in the next
`define CSDM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/csdm_pkg.sv -----
// ----------------------------------------------------------------------------
// csdm_pkg
// shared types, constants and helpers of the capture merge core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csdm_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ROW_BITS_DEF  = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [1:0]  PASS_ROWS     = 2'd2;

  // one queued result: delta is sat_add(delta_a, delta_b)
  typedef struct packed {
    logic [DATA_W-1:0] bits;
    logic [DATA_W-1:0] delta_a;
    logic [DATA_W-1:0] delta_b;
    logic              last;
  } rec_t;

  typedef enum logic [1:0] {
    ROW_PASS = 2'd0,
    ROW_DUP  = 2'd1,
    ROW_NEW  = 2'd2
  } row_kind_t;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

endpackage

// ----- rtl/core/csdm_front.sv -----
// ----------------------------------------------------------------------------
// csdm_front
// row classifier: compares against the previous row, keeps the carry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csdm_front #(
  parameter int unsigned ROW_BITS = csdm_pkg::ROW_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [csdm_pkg::DATA_W-1:0]  sample_bits,
  input  logic [csdm_pkg::DATA_W-1:0]  time_delta,
  input  logic                         end_of_capture,
  input  logic                         q_full,
  output logic                         q_push,
  output csdm_pkg::rec_t               q_rec
);

  localparam int unsigned CMP_BITS = (ROW_BITS < csdm_pkg::DATA_W) ? ROW_BITS
                                                                 : csdm_pkg::DATA_W;
  localparam logic [csdm_pkg::DATA_W-1:0] ROW_MASK =
    (CMP_BITS >= csdm_pkg::DATA_W) ? {csdm_pkg::DATA_W{1'b1}}
                                   : csdm_pkg::DATA_W'((64'd1 << CMP_BITS) - 64'd1);

  logic [CMP_BITS-1:0]         prev_row_r;
  logic [1:0]                  rows_seen_r, rows_seen_nxt;
  logic [csdm_pkg::DATA_W-1:0] carry_r, carry_nxt;
  logic [csdm_pkg::DATA_W-1:0] masked;
  csdm_pkg::row_kind_t         kind;
  logic                        accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign masked    = sample_bits & ROW_MASK;

  always_comb begin
    if (rows_seen_r < csdm_pkg::PASS_ROWS) begin
      kind = csdm_pkg::ROW_PASS;
    end else if (masked[CMP_BITS-1:0] == prev_row_r) begin
      kind = csdm_pkg::ROW_DUP;
    end else begin
      kind = csdm_pkg::ROW_NEW;
    end
  end

  always_comb begin
    rows_seen_nxt = rows_seen_r;
    carry_nxt     = carry_r;
    q_push        = 1'b0;
    q_rec.bits    = masked;
    q_rec.last    = end_of_capture;
    q_rec.delta_a = carry_r;
    q_rec.delta_b = time_delta;
    unique case (kind)
      csdm_pkg::ROW_PASS: begin
        q_push        = accept;
        q_rec.delta_a = time_delta;
        q_rec.delta_b = '0;
        rows_seen_nxt = rows_seen_r + 2'd1;
      end
      csdm_pkg::ROW_DUP: begin
        q_push    = accept && end_of_capture;
        carry_nxt = csdm_pkg::sat_add(carry_r, time_delta);
      end
      csdm_pkg::ROW_NEW: begin
        q_push    = accept;
        carry_nxt = '0;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
    if (end_of_capture) begin
      rows_seen_nxt = '0;
      carry_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_seen_r <= '0;
      carry_r     <= '0;
      prev_row_r  <= '0;
    end else if (accept) begin
      rows_seen_r <= rows_seen_nxt;
      carry_r     <= carry_nxt;
      prev_row_r  <= masked[CMP_BITS-1:0];
    end
  end

  `CSDM_ASSERT(a_rows_bound, clk, rst_n, rows_seen_r <= csdm_pkg::PASS_ROWS,
               "rows_seen beyond pass count")
  `CSDM_ASSERT(a_carry_idle, clk, rst_n,
               (rows_seen_r == csdm_pkg::PASS_ROWS) || (carry_r == '0),
               "carry nonzero during pass rows")

endmodule

// ----- rtl/core/csdm_queue.sv -----
// ----------------------------------------------------------------------------
// csdm_queue
// small register fifo between classifier and output stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csdm_queue #(
  parameter int unsigned DEPTH = csdm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  csdm_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output csdm_pkg::rec_t pop_rec
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  csdm_pkg::rec_t   entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign valid   = (count_r != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign pop_rec = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_rec;
    end
  end

  `CSDM_ASSERT_NEXT(a_cnt_up, clk, rst_n, do_push && !do_pop,
                    count_r == $past(count_r) + CNT_W'(1), "fifo count did not grow")

endmodule

// ----- rtl/core/csdm_back.sv -----
// ----------------------------------------------------------------------------
// csdm_back
// output stage: forms the merged delta and holds the result for the sink
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csdm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  csdm_pkg::rec_t              q_rec,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [csdm_pkg::DATA_W-1:0] kept_bits,
  output logic [csdm_pkg::DATA_W-1:0] kept_delta,
  output logic                        final_flag
);

  logic                        valid_r;
  logic [csdm_pkg::DATA_W-1:0] bits_r, delta_r;
  logic                        last_r;

  assign q_pop      = q_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign kept_bits  = bits_r;
  assign kept_delta = delta_r;
  assign final_flag = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bits_r  <= q_rec.bits;
      delta_r <= csdm_pkg::sat_add(q_rec.delta_a, q_rec.delta_b);
      last_r  <= q_rec.last;
    end
  end

endmodule

// ----- rtl/core/capture_sample_duplicate_merge_core.sv -----
// ----------------------------------------------------------------------------
// capture_sample_duplicate_merge_core
// run-length merge of repeated timestamped capture rows
// ----------------------------------------------------------------------------
// Takes one capture row per cycle. The first two rows of a capture pass
// through; a later row equal to the previous one is dropped and its delta
// joins a saturating carry, which the next differing row (or the final
// row) carries out. A row is classified and the carry updated in the
// cycle it is accepted, so one row per cycle is sustained as long as the
// sink takes results; a kept row is written into the fifo and then into
// the output register. A small fifo of QUEUE_DEPTH entries decouples
// input from output, so input keeps flowing for that many results while
// the output stalls.
`timescale 1ns / 1ps

module capture_sample_duplicate_merge_core #(
  parameter int unsigned ROW_BITS    = csdm_pkg::ROW_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = csdm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sample_bits[31:0], time_delta[63:32]
  input  logic        in_tlast,   // end_of_capture
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // kept_bits[31:0], kept_delta[63:32]
  output logic        out_tlast   // final_flag
);

  logic           q_push, q_full, q_pop, q_valid;
  csdm_pkg::rec_t push_rec, pop_rec;
  logic [csdm_pkg::DATA_W-1:0] kept_bits, kept_delta;

  csdm_front #(.ROW_BITS(ROW_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .sample_bits   (in_tdata[31:0]),
    .time_delta    (in_tdata[63:32]),
    .end_of_capture(in_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_rec         (push_rec)
  );

  csdm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_rec(push_rec),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .pop_rec (pop_rec)
  );

  csdm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rec     (pop_rec),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .kept_bits (kept_bits),
    .kept_delta(kept_delta),
    .final_flag(out_tlast)
  );

  assign out_tdata = {kept_delta, kept_bits};

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the capture row duplicate merge core
// ----------------------------------------------------------------------------
// Streams timestamped capture rows into the core and predicts every kept
// row: the two pass-through rows of a capture, duplicates folded into a
// saturating carry, and the closing row of each capture. A short directed
// run covers the field extremes, saturation and the early and duplicate
// final rows. Random captures follow, built mostly from small pools of
// rows so that duplicate runs are common, with some fully random noise.
// Source gaps and sink stalls change from phase to phase.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ROW_W = csdm_pkg::ROW_BITS_DEF;
  localparam logic [31:0] DELTA_TOP = 32'hFFFF_FFFF;

  class row_merge_predictor;
    typedef struct {
      logic [31:0] bits;
      logic [31:0] delta;
      logic        last;
    } kept_row_t;

    kept_row_t   kept_due[$];
    logic [31:0] row_mask;
    logic [31:0] last_row;
    logic [31:0] carry;
    logic [1:0]  rows_in_capture;
    int unsigned mismatches;
    int unsigned kept_checked;

    function new(int unsigned row_w);
      row_mask = (row_w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << row_w) - 32'd1);
      last_row = '0;
      carry = '0;
      rows_in_capture = '0;
      mismatches = 0;
      kept_checked = 0;
    endfunction

    function logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[32] ? DELTA_TOP : total[31:0];
    endfunction

    function void note_row(logic [31:0] raw_bits, logic [31:0] delta, logic last);
      logic [31:0] bits;
      kept_row_t   r;
      logic        emit;
      bits = raw_bits & row_mask;
      emit = 1'b1;
      r.delta = delta;
      if (rows_in_capture < csdm_pkg::PASS_ROWS) begin
        rows_in_capture = rows_in_capture + 2'd1;
      end else if (bits == last_row) begin
        carry = clamp_add(carry, delta);
        emit = last;
        r.delta = carry;
      end else begin
        r.delta = clamp_add(carry, delta);
        carry = '0;
      end
      last_row = bits;
      if (last) begin
        rows_in_capture = '0;
        carry = '0;
      end
      if (emit) begin
        r.bits = bits;
        r.last = last;
        kept_due = {kept_due, r};
      end
    endfunction

    function void check_kept(logic [31:0] bits, logic [31:0] delta, logic last);
      kept_row_t r;
      if (kept_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected kept row: bits %h delta %h last %b", bits, delta, last);
        return;
      end
      r = kept_due.pop_front();
      kept_checked++;
      if (r.bits !== bits || r.delta !== delta || r.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("kept row mismatch: expected bits %h delta %h last %b, got %h %h %b",
                   r.bits, r.delta, r.last, bits, delta, last);
      end
    endfunction

    function int pending();
      return kept_due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // sample_bits[31:0], time_delta[63:32]
  logic        in_tlast = 1'b0; // end_of_capture
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // kept_bits[31:0], kept_delta[63:32]
  logic        out_tlast;       // final_flag

  row_merge_predictor merge_model;
  int unsigned        send_idle_pct = 0;
  int unsigned        sink_stall_pct = 0;
  int unsigned        rows_sent = 0;
  int unsigned        captures_sent = 0;

  capture_sample_duplicate_merge_core #(.ROW_BITS(ROW_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        merge_model.note_row(in_tdata[31:0], in_tdata[63:32], in_tlast);
      if (out_tvalid && out_tready)
        merge_model.check_kept(out_tdata[31:0], out_tdata[63:32], out_tlast);
    end
  end

  task automatic send_row(logic [31:0] bits, logic [31:0] delta, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {delta, bits};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    rows_sent++;
    if (last)
      captures_sent++;
  endtask

  task automatic send_random_capture();
    int unsigned len;
    bit          noise;
    logic [31:0] pool [3];
    logic [31:0] bits;
    logic [31:0] delta;
    int unsigned pick;
    len = $urandom_range(1, 14);
    noise = ($urandom_range(99) < 10);
    pool[0] = $urandom;
    pool[1] = pool[0] ^ (32'd1 << $urandom_range(31));
    pool[2] = $urandom;
    bits = pool[$urandom_range(2)];
    for (int unsigned i = 0; i < len; i++) begin
      if (noise)
        bits = $urandom;
      else if (i > 0 && $urandom_range(99) >= 55)
        bits = pool[$urandom_range(2)];
      pick = $urandom_range(99);
      if (pick < 80)
        delta = $urandom_range(1000);
      else if (pick < 92)
        delta = $urandom;
      else
        delta = DELTA_TOP - $urandom_range(15);
      send_row(bits, delta, i == len - 1);
    end
  endtask

  initial begin
    merge_model = new(ROW_W);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-row capture at the top of both fields
    send_row(32'hFFFF_FFFF, DELTA_TOP, 1'b1);
    // final on the second row, equal rows still pass
    send_row(32'h0000_0000, 32'h0, 1'b0);
    send_row(32'h0000_0000, 32'h5, 1'b1);
    // duplicate run whose carry saturates the next row's delta, then a duplicate final row
    send_row(32'h1234_5678, 32'h1, 1'b0);
    send_row(32'h1234_5678, 32'h2, 1'b0);
    send_row(32'h1234_5678, 32'h3, 1'b0);
    send_row(32'h1234_5678, 32'hFFFF_FFF0, 1'b0);
    send_row(32'h8765_4321, 32'd100, 1'b0);
    send_row(32'h8765_4321, 32'd7, 1'b0);
    send_row(32'h8765_4321, 32'd9, 1'b1);
    // differing final row after the pass rows
    send_row(32'hAAAA_AAAA, 32'd3, 1'b0);
    send_row(32'h5555_5555, 32'd4, 1'b0);
    send_row(32'hA5A5_A5A5, 32'd0, 1'b1);
    // new capture starting on the previous final row, exact overflow of the carry
    send_row(32'hA5A5_A5A5, 32'd1, 1'b0);
    send_row(32'hA5A5_A5A5, 32'd2, 1'b0);
    send_row(32'hA5A5_A5A5, 32'h8000_0000, 1'b0);
    send_row(32'hA5A5_A5A5, 32'h7FFF_FFFF, 1'b0);
    send_row(32'h0000_0001, 32'd0, 1'b0);
    send_row(32'h0000_0001, 32'h8000_0000, 1'b0);
    send_row(32'h0000_0001, 32'h8000_0000, 1'b0);
    send_row(32'h8000_0000, 32'd1, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 49; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 49; end
        default: begin send_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      while (rows_sent < 21 + 150 * (phase + 1))
        send_random_capture();
    end
    in_tvalid <= 1'b0;
    sink_stall_pct = 0;

    while (merge_model.pending() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d rows in %0d captures, checked %0d kept rows, %0d mismatches",
             rows_sent, captures_sent, merge_model.kept_checked, merge_model.mismatches);
    $display("phases ran with no gaps, source gaps, sink stalls and both");
    if (merge_model.mismatches == 0 && merge_model.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- capture_sample_duplicate_merge_core.f -----
+incdir+rtl/core
rtl/core/csdm_pkg.sv
rtl/core/csdm_front.sv
rtl/core/csdm_queue.sv
rtl/core/csdm_back.sv
rtl/core/capture_sample_duplicate_merge_core.sv
sim/tb.sv
